/* rtl/csrmv_pkg.sv */
// Shared types and constants for the CSR sparse matrix-vector engine.
// No dependencies; every other file in rtl/ uses this package.
package csrmv_pkg;

    localparam int unsigned VAL_W        = 32;
    localparam int unsigned IDX_W        = 12;
    localparam int unsigned ROW_W        = 12;
    localparam int unsigned SUM_W        = 64;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned X_DEPTH_DEF  = 4096;
    localparam int unsigned MAX_ROWS_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 1'b0,
        CFG_BETA  = 1'b1
    } t_cfg_reg;

    localparam logic signed [VAL_W-1:0] ALPHA_RST = 32'sh0001_0000;
    localparam logic signed [VAL_W-1:0] BETA_RST  = 32'sh0000_0000;

    // one nonzero after the x lookup, handed from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] x_val;
        logic        [ROW_W-1:0] row;
        logic signed [VAL_W-1:0] old_y;
        logic                    last;
    } t_work;

    typedef struct packed {
        logic signed [VAL_W-1:0] alpha;
        logic signed [VAL_W-1:0] beta;
    } t_gains;

endpackage

/* rtl/csrmv_item_if.sv */
// Input channel: one vector load or one matrix nonzero per transfer.
// Depends on csrmv_pkg for field widths.
interface csrmv_item_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic        [csrmv_pkg::IDX_W-1:0] index;
    logic signed [csrmv_pkg::VAL_W-1:0] value;
    logic        [csrmv_pkg::ROW_W-1:0] row;
    logic signed [csrmv_pkg::VAL_W-1:0] old_y;
    logic                              last_in_row;

    modport source (output valid, mode, index, value, row, old_y, last_in_row, input ready);
    modport sink   (input valid, mode, index, value, row, old_y, last_in_row, output ready);
endinterface

/* rtl/csrmv_result_if.sv */
// Output channel: one finished row result per transfer.
// Depends on csrmv_pkg for field widths.
interface csrmv_result_if;
    logic                              valid;
    logic                              ready;
    logic        [csrmv_pkg::ROW_W-1:0] out_row;
    logic signed [csrmv_pkg::VAL_W-1:0] y_out;

    modport source (output valid, out_row, y_out, input ready);
    modport sink   (input valid, out_row, y_out, output ready);
endinterface

/* rtl/csrmv_front.sv */
// Front end: takes input transfers, owns the x vector store, looks up x
// for each nonzero and pushes the result into the work queue. Uses csrmv_pkg.
module csrmv_front #(
    parameter int unsigned X_DEPTH  = csrmv_pkg::X_DEPTH_DEF,
    parameter int unsigned MAX_ROWS = csrmv_pkg::MAX_ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    csrmv_item_if.sink        s_item,
    output logic              o_push,
    output csrmv_pkg::t_work  o_push_data,
    input  logic              i_full
);

    localparam int unsigned AW  = $clog2(X_DEPTH);
    localparam int unsigned CW  = ((AW > csrmv_pkg::IDX_W) ? AW : csrmv_pkg::IDX_W) + 1;
    localparam int unsigned RB  = $clog2(MAX_ROWS + 1);
    localparam int unsigned RCW = ((RB > csrmv_pkg::ROW_W) ? RB : csrmv_pkg::ROW_W) + 1;

    logic [csrmv_pkg::VAL_W-1:0] r_mem [X_DEPTH];
    logic [csrmv_pkg::VAL_W-1:0] r_rd;

    logic                               r_s1_vld;
    logic                               r_s1_col_ok;
    logic signed [csrmv_pkg::VAL_W-1:0] r_s1_value;
    logic        [csrmv_pkg::ROW_W-1:0] r_s1_row;
    logic signed [csrmv_pkg::VAL_W-1:0] r_s1_old_y;
    logic                               r_s1_last;

    logic          w_acc;
    logic [CW-1:0] w_idx_ext;
    logic          w_col_ok;
    logic [AW-1:0] w_addr;
    logic          w_row_ok;

    assign w_idx_ext = CW'(s_item.index);
    assign w_col_ok  = w_idx_ext < CW'(X_DEPTH);
    assign w_addr    = w_idx_ext[AW-1:0];
    assign w_row_ok  = RCW'(s_item.row) < RCW'(MAX_ROWS);

    assign s_item.ready = !r_s1_vld || !i_full;
    assign w_acc        = s_item.valid && s_item.ready;
    assign o_push       = r_s1_vld && !i_full;

    always_comb begin
        o_push_data.value = r_s1_value;
        o_push_data.x_val = r_s1_col_ok ? r_rd : '0;
        o_push_data.row   = r_s1_row;
        o_push_data.old_y = r_s1_old_y;
        o_push_data.last  = r_s1_last;
    end

    // x store: written by loads, read by nonzeros, read data registered
    always_ff @(posedge i_clk) begin
        if (w_acc && !s_item.mode && w_col_ok) begin
            r_mem[w_addr] <= s_item.value;
        end
        if (w_acc && s_item.mode && w_col_ok) begin
            r_rd <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_acc) begin
            // rows out of range are dropped here, accumulator untouched
            r_s1_vld <= s_item.mode && w_row_ok;
        end else if (o_push) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_col_ok <= w_col_ok;
            r_s1_value  <= s_item.value;
            r_s1_row    <= s_item.row;
            r_s1_old_y  <= s_item.old_y;
            r_s1_last   <= s_item.last_in_row;
        end
    end

endmodule

/* rtl/csrmv_queue.sv */
// Short FIFO of looked-up nonzeros between front end and back end.
// Uses csrmv_pkg::t_work; DEPTH must be a power of two, at least 2.
module csrmv_queue #(
    parameter int unsigned DEPTH = csrmv_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  csrmv_pkg::t_work i_data,
    output logic             o_full,
    input  logic             i_pop,
    output csrmv_pkg::t_work o_data,
    output logic             o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);

    csrmv_pkg::t_work r_buf [DEPTH];
    logic [PW:0]      r_wr;
    logic [PW:0]      r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PW] != r_rd[PW]) && (r_wr[PW-1:0] == r_rd[PW-1:0]);
    assign o_data  = r_buf[r_rd[PW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_buf[r_wr[PW-1:0]] <= i_data;
        end
    end

endmodule

/* rtl/csrmv_back.sv */
// Back end: multiply-accumulate of nonzeros and the row finish
// alpha*sum + beta*old_y with rounding and saturation. Uses csrmv_pkg.
module csrmv_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csrmv_pkg::t_gains i_gains,
    input  logic              i_empty,
    input  csrmv_pkg::t_work  i_head,
    output logic              o_pop,
    csrmv_result_if.source    m_res
);

    localparam int unsigned ACC_W = 96;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sh0000_0000_8000_0000);
    localparam logic signed [csrmv_pkg::VAL_W-1:0] Y_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [csrmv_pkg::VAL_W-1:0] Y_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_OUT
    } t_state;

    t_state                             r_state;
    logic signed [csrmv_pkg::SUM_W-1:0] r_prod;
    logic signed [csrmv_pkg::SUM_W-1:0] r_sum;
    logic        [csrmv_pkg::ROW_W-1:0] r_row;
    logic signed [csrmv_pkg::VAL_W-1:0] r_old_y;
    logic                               r_last;
    logic signed [csrmv_pkg::SUM_W:0]   r_pl;
    logic signed [csrmv_pkg::SUM_W-1:0] r_bp;
    logic signed [csrmv_pkg::SUM_W-1:0] r_ph;
    logic signed [ACC_W-1:0]            r_part;
    logic signed [ACC_W-1:0]            r_acc;
    logic                               r_out_vld;
    logic        [csrmv_pkg::ROW_W-1:0] r_out_row;
    logic signed [csrmv_pkg::VAL_W-1:0] r_y;

    logic signed [csrmv_pkg::SUM_W-1:0] w_prod;
    logic signed [csrmv_pkg::SUM_W-1:0] w_sum_raw;
    logic signed [csrmv_pkg::SUM_W-1:0] w_sum_sat;
    logic signed [ACC_W-1:0]            w_part;
    logic signed [ACC_W-1:0]            w_acc;
    logic                               w_fits;
    logic signed [csrmv_pkg::VAL_W-1:0] w_y;
    logic                               w_out_free;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign w_prod    = i_head.value * i_head.x_val;
    assign w_sum_raw = r_sum + r_prod;

    // saturate when both addends share a sign the sum lost
    always_comb begin
        w_sum_sat = w_sum_raw;
        if (r_sum[csrmv_pkg::SUM_W-1] == r_prod[csrmv_pkg::SUM_W-1] &&
            w_sum_raw[csrmv_pkg::SUM_W-1] != r_sum[csrmv_pkg::SUM_W-1]) begin
            w_sum_sat = r_sum[csrmv_pkg::SUM_W-1] ?
                        {1'b1, {(csrmv_pkg::SUM_W-1){1'b0}}} :
                        {1'b0, {(csrmv_pkg::SUM_W-1){1'b1}}};
        end
    end

    // sum = hi*2^32 + lo: alpha*lo and beta*old_y first, then alpha*hi
    assign w_part = ACC_W'(r_pl) + (ACC_W'(r_bp) <<< 16) + RND;
    assign w_acc  = (ACC_W'(r_ph) <<< 32) + r_part;

    assign w_fits = (&r_acc[ACC_W-1:63]) || !(|r_acc[ACC_W-1:63]);
    assign w_y    = w_fits ? r_acc[63:32] : (r_acc[ACC_W-1] ? Y_MIN : Y_MAX);

    assign w_out_free = !r_out_vld || m_res.ready;

    assign m_res.valid   = r_out_vld;
    assign m_res.out_row = r_out_row;
    assign m_res.y_out   = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // a new result may take the slot in the cycle the old one leaves
            if (r_state == S_OUT && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_res.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_prod  <= w_prod;
                        r_row   <= i_head.row;
                        r_old_y <= i_head.old_y;
                        r_last  <= i_head.last;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum   <= w_sum_sat;
                    r_state <= r_last ? S_FIN1 : S_IDLE;
                end
                S_FIN1: begin
                    r_pl    <= $signed({1'b0, r_sum[31:0]}) * i_gains.alpha;
                    r_bp    <= i_gains.beta * r_old_y;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_ph    <= $signed(r_sum[63:32]) * i_gains.alpha;
                    r_part  <= w_part;
                    r_state <= S_FIN3;
                end
                S_FIN3: begin
                    r_acc   <= w_acc;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_row <= r_row;
                        r_y       <= w_y;
                        r_sum     <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/csr_sparse_matvec_axpby_unit.sv */
// Throughput: vector loads 1 per cycle while i_item.ready is high. The back-end
//   sequencer takes a new nonzero only once the last is accumulated (pop+multiply,
//   then saturating accumulate); a row end holds it through S_FIN1..S_FIN3 and S_OUT.
// The front end and 4-entry queue keep accepting while the back end works, until full.
// Reset (i_rst_n, synchronous, active low): clears handshake state, accumulator,
//   gains (alpha = 1.0, beta = 0); the x store is not cleared.
module csr_sparse_matvec_axpby_unit #(
    parameter int unsigned X_DEPTH  = csrmv_pkg::X_DEPTH_DEF,
    parameter int unsigned MAX_ROWS = csrmv_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csrmv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [csrmv_pkg::VAL_W-1:0]       i_cfg_data,
    csrmv_item_if.sink                        i_item,
    csrmv_result_if.source                    o_result
);

    // Configuration registers; the user must write them only while the engine is idle (not enforced here).
    logic signed [csrmv_pkg::VAL_W-1:0] r_alpha;
    logic signed [csrmv_pkg::VAL_W-1:0] r_beta;
    csrmv_pkg::t_gains                  w_gains;

    // Front end to queue
    logic             w_push;
    csrmv_pkg::t_work w_push_data;
    logic             w_full;

    // Queue to back end
    logic             w_pop;
    csrmv_pkg::t_work w_head;
    logic             w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= csrmv_pkg::ALPHA_RST;
            r_beta  <= csrmv_pkg::BETA_RST;
        end else if (i_cfg_we) begin
            case (csrmv_pkg::t_cfg_reg'(i_cfg_idx))
                csrmv_pkg::CFG_ALPHA: begin
                    r_alpha <= i_cfg_data;
                end
                csrmv_pkg::CFG_BETA: begin
                    r_beta <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_gains.alpha = r_alpha;
    assign w_gains.beta  = r_beta;

    // Front: x store writes for loads, x lookup for nonzeros, row range filter.
    csrmv_front #(
        .X_DEPTH  (X_DEPTH),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_item      (i_item),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    // Decoupling queue: lets loads and lookups run ahead of the MAC sequencer.
    csrmv_queue #(
        .DEPTH (csrmv_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_empty (w_empty)
    );

    // Back: Q32.32 saturating accumulate, then alpha*sum + beta*old_y on a row end,
    // rounded to nearest and saturated to Q16.16, into a registered output.
    csrmv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gains (w_gains),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .m_res   (o_result)
    );

endmodule
